/* rtl/sst_pkg.sv */
// sst_pkg: shared types and constants of the sorted set table.
// Used by sst_front, sst_back and sorted_set_table; depends on nothing.
package sst_pkg;

    localparam int CAPACITY    = 16;
    localparam int KEY_W       = 32;
    localparam int FUNC_W      = 2;
    localparam int ECOUNT_W    = 5;
    localparam int COUNT_W     = $clog2(CAPACITY + 1);
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_SEARCH = 2'd2;

    typedef enum logic [1:0] {
        OP_INSERT,
        OP_REMOVE,
        OP_SEARCH,
        OP_NONE
    } op_t;

    typedef struct packed {
        op_t                     op;
        logic signed [KEY_W-1:0] key;
    } req_t;

endpackage

/* rtl/sst_front.sv */
// sst_front: accepts request beats, decodes the function code and holds
// the decoded requests in a short queue. Depends on sst_pkg.
module sst_front (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [sst_pkg::FUNC_W-1:0]      func,
    input  logic signed [sst_pkg::KEY_W-1:0] key,
    output logic                            q_valid,
    output sst_pkg::req_t                   q_req,
    input  logic                            q_take
);

    sst_pkg::req_t                queue_reg [sst_pkg::QUEUE_DEPTH];
    logic [sst_pkg::QPTR_W-1:0]   wr_ptr_reg;
    logic [sst_pkg::QPTR_W-1:0]   wr_ptr_next;
    logic [sst_pkg::QPTR_W-1:0]   rd_ptr_reg;
    logic [sst_pkg::QPTR_W-1:0]   rd_ptr_next;
    logic [sst_pkg::QCNT_W-1:0]   cnt_reg;
    logic [sst_pkg::QCNT_W-1:0]   cnt_next;
    sst_pkg::req_t                dec_req;
    logic                         push;
    logic                         pop;

    // Classify the function code; the unused code becomes a no-op.
    always_comb
    begin
        dec_req.key = key;
        case (func)
            sst_pkg::FUNC_INSERT: dec_req.op = sst_pkg::OP_INSERT;
            sst_pkg::FUNC_REMOVE: dec_req.op = sst_pkg::OP_REMOVE;
            sst_pkg::FUNC_SEARCH: dec_req.op = sst_pkg::OP_SEARCH;
            default:              dec_req.op = sst_pkg::OP_NONE;
        endcase
    end

    assign in_stall = (cnt_reg == sst_pkg::QCNT_W'(sst_pkg::QUEUE_DEPTH));
    assign q_valid  = (cnt_reg != '0);
    assign q_req    = queue_reg[rd_ptr_reg];
    assign push     = in_valid && !in_stall;
    assign pop      = q_valid && q_take;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_reg[wr_ptr_reg] <= dec_req;
        end
    end

endmodule

/* rtl/sst_back.sv */
// sst_back: row of key cells kept in ascending order, compared in parallel,
// shifted on insert and remove; registers one result beat. Depends on sst_pkg.
module sst_back (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           q_valid,
    input  sst_pkg::req_t                  q_req,
    output logic                           q_take,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic                           success,
    output logic                           full_refused,
    output logic [sst_pkg::ECOUNT_W-1:0]   element_count
);

    logic signed [sst_pkg::KEY_W-1:0] keys_reg  [sst_pkg::CAPACITY];
    logic signed [sst_pkg::KEY_W-1:0] keys_next [sst_pkg::CAPACITY];
    logic signed [sst_pkg::KEY_W-1:0] up_key    [sst_pkg::CAPACITY];
    logic signed [sst_pkg::KEY_W-1:0] down_key  [sst_pkg::CAPACITY];
    logic [sst_pkg::CAPACITY-1:0]     less;
    logic [sst_pkg::CAPACITY-1:0]     equal;
    logic [sst_pkg::CAPACITY-1:0]     at_pos;
    logic [sst_pkg::COUNT_W-1:0]      count_reg;
    logic [sst_pkg::COUNT_W-1:0]      count_next;
    logic                             out_valid_reg;
    logic                             success_reg;
    logic                             refused_reg;
    logic [sst_pkg::ECOUNT_W-1:0]     ecount_reg;
    logic                             held;
    logic                             full;
    logic                             ok;
    logic                             refused;

    assign q_take = q_valid && (!out_valid_reg || !out_stall);

    // Per-cell compare and neighbor taps.
    for (genvar i = 0; i < sst_pkg::CAPACITY; i++)
    begin : g_cell
        logic live;
        assign live     = (sst_pkg::COUNT_W'(i) < count_reg);
        assign less[i]  = live && (keys_reg[i] < q_req.key);
        assign equal[i] = live && (keys_reg[i] == q_req.key);
        if (i == 0)
        begin : g_first
            assign up_key[i] = q_req.key;
            assign at_pos[i] = !less[i];
        end
        else
        begin : g_rest
            assign up_key[i] = keys_reg[i-1];
            assign at_pos[i] = !less[i] && less[i-1];
        end
        if (i == sst_pkg::CAPACITY - 1)
        begin : g_last
            assign down_key[i] = keys_reg[i];
        end
        else
        begin : g_inner
            assign down_key[i] = keys_reg[i+1];
        end
    end

    assign held = |equal;
    assign full = (count_reg == sst_pkg::COUNT_W'(sst_pkg::CAPACITY));

    always_comb
    begin
        keys_next  = keys_reg;
        count_next = count_reg;
        ok         = 1'b0;
        refused    = 1'b0;
        case (q_req.op)
            sst_pkg::OP_INSERT:
            begin
                if (!held)
                begin
                    if (full)
                    begin
                        refused = 1'b1;
                    end
                    else
                    begin
                        // Keep cells below the slot, write the key there, shift the rest up.
                        for (int i = 0; i < sst_pkg::CAPACITY; i++)
                        begin
                            if (at_pos[i])
                            begin
                                keys_next[i] = q_req.key;
                            end
                            else if (!less[i])
                            begin
                                keys_next[i] = up_key[i];
                            end
                        end
                        count_next = count_reg + 1'b1;
                        ok         = 1'b1;
                    end
                end
            end
            sst_pkg::OP_REMOVE:
            begin
                if (held)
                begin
                    // Close the gap: cells from the match upward take their upper neighbor.
                    for (int i = 0; i < sst_pkg::CAPACITY; i++)
                    begin
                        if (!less[i])
                        begin
                            keys_next[i] = down_key[i];
                        end
                    end
                    count_next = count_reg - 1'b1;
                    ok         = 1'b1;
                end
            end
            sst_pkg::OP_SEARCH:
            begin
                ok = held;
            end
            default:
            begin
                ok = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (q_take)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_take)
        begin
            keys_reg    <= keys_next;
            success_reg <= ok;
            refused_reg <= refused;
            ecount_reg  <= sst_pkg::ECOUNT_W'(count_next);
        end
    end

    assign out_valid     = out_valid_reg;
    assign success       = success_reg;
    assign full_refused  = refused_reg;
    assign element_count = ecount_reg;

endmodule

/* rtl/sorted_set_table.sv */
// sorted_set_table: top level of the bounded sorted key set.
// Instantiates sst_front and sst_back; depends on sst_pkg.
//
// Usage:
//   Request channel: in_valid / in_stall with func (insert, remove, search)
//   and a signed 32-bit key. A beat is taken when in_valid is high and
//   in_stall is low. in_stall rises only when the four-entry request queue
//   is full.
//   Result channel: out_valid / out_stall with success, full_refused and
//   element_count (keys held after the request). Exactly one result beat
//   per request beat, in request order.
// A taken request is written into the request queue, then its result is
//   registered in the back end. Throughput: one request per cycle while
//   out_stall is low, set by the parallel compare and shift over all 16 key cells.
// Reset: rst_n clears the queue, the key count (set empty) and the result valid
//   flag; key cells are not cleared, only cells below the count are used.
// Stall: while out_stall is high a pending result beat holds and the back
//   end takes no request while it holds one; the queue absorbs up to four
//   more request beats before in_stall rises.
module sorted_set_table (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [sst_pkg::FUNC_W-1:0]       func,
    input  logic signed [sst_pkg::KEY_W-1:0] key,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic                             success,
    output logic                             full_refused,
    output logic [sst_pkg::ECOUNT_W-1:0]     element_count
);

    // Decoded request queue between front and back.
    logic          q_valid;
    logic          q_take;
    sst_pkg::req_t q_req;

    // Front: accept and classify request beats, hold them in the queue.
    sst_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .func     (func),
        .key      (key),
        .q_valid  (q_valid),
        .q_req    (q_req),
        .q_take   (q_take)
    );

    // Back: search, insert or remove against the key cells, register the result.
    sst_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_req         (q_req),
        .q_take        (q_take),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .success       (success),
        .full_refused  (full_refused),
        .element_count (element_count)
    );

endmodule

/* tb/tb.sv */
// tb: self-checking testbench for sorted_set_table, a bounded sorted set of signed keys.
// Depends on sst_pkg and the sorted_set_table RTL; needs no files or arguments.
// Drives request beats, predicts every result beat and compares them field by field.
module tb;
    import sst_pkg::*;

    localparam int QUIET_LIMIT = 2000;   // cycles with no beat on either side
    localparam int IDLE_PCT    = 22;

    typedef struct packed {
        logic                success;
        logic                full_refused;
        logic [ECOUNT_W-1:0] element_count;
    } outcome_t;

    logic                    clk;
    logic                    rst_n;
    logic                    in_valid;
    logic                    in_stall;
    logic [FUNC_W-1:0]       func;
    logic signed [KEY_W-1:0] key;
    logic                    out_valid;
    logic                    out_stall;
    logic                    success;
    logic                    full_refused;
    logic [ECOUNT_W-1:0]     element_count;

    sorted_set_table dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .func          (func),
        .key           (key),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .success       (success),
        .full_refused  (full_refused),
        .element_count (element_count)
    );

    // Shadow copy of the set: held keys ascending in slots 0 .. set_size-1.
    logic signed [KEY_W-1:0] set_keys [CAPACITY];
    int                      set_size;

    outcome_t                pending_results [$];
    outcome_t                want;
    int                      mismatches;
    int unsigned             quiet_cycles;
    bit                      steady;            // suppress idling on both sides
    logic signed [KEY_W-1:0] key_pool [20];

    initial clk = 1'b0;
    always #1 clk = ~clk;

    // Apply one request to the shadow set and return the result it must produce.
    function automatic outcome_t apply_request(input op_t op,
                                               input logic signed [KEY_W-1:0] k);
        int       pos;
        int       i;
        bit       held;
        outcome_t r;
        pos = 0;
        while (pos < set_size && set_keys[pos] < k)
            pos++;
        held = (pos < set_size) && (set_keys[pos] == k);
        r = '0;
        case (op)
            OP_INSERT:
                if (!held)
                begin
                    if (set_size >= CAPACITY)
                    begin
                        r.full_refused = 1'b1;
                    end
                    else
                    begin
                        for (i = set_size; i > pos; i--)
                            set_keys[i] = set_keys[i-1];
                        set_keys[pos] = k;
                        set_size++;
                        r.success = 1'b1;
                    end
                end
            OP_REMOVE:
                if (held)
                begin
                    for (i = pos; i + 1 < set_size; i++)
                        set_keys[i] = set_keys[i+1];
                    set_size--;
                    r.success = 1'b1;
                end
            OP_SEARCH: r.success = held;
            default:   ;
        endcase
        r.element_count = set_size[ECOUNT_W-1:0];
        return r;
    endfunction

    function automatic void log_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("tb: mismatch: %s", msg);
    endfunction

    // Send one request beat. Called at a rising edge; returns at the edge that takes the beat,
    // so the caller must drive in_valid again in that same step (next beat or drain).
    task automatic send_req(input op_t op, input logic signed [KEY_W-1:0] k);
        // Insert idle cycles at random so the input side rests in about IDLE_PCT of its cycles.
        if (!steady)
        begin
            while ($urandom_range(0, 99) < IDLE_PCT)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        end
        in_valid <= 1'b1;
        func     <= op;
        key      <= k;
        // Sample the stall mid-cycle; a low stall here means the next edge takes the beat.
        @(negedge clk);
        while (in_stall)
            @(negedge clk);
        pending_results.push_back(apply_request(op, k));
        @(posedge clk);
    endtask

    // Drop valid, wait for every expected result, then allow the pipeline to settle.
    task automatic drain();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    function automatic logic signed [KEY_W-1:0] pick_key(input int mode);
        case (mode)
            0:       return KEY_W'($urandom_range(0, 40)) - 32'sd20;
            1:       return key_pool[$urandom_range(0, 19)];
            default: return $urandom;
        endcase
    endfunction

    function automatic op_t pick_op(input int ins_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < ins_pct)
            return OP_INSERT;
        if (r < ins_pct + (95 - ins_pct) / 2)
            return OP_REMOVE;
        if (r < 95)
            return OP_SEARCH;
        return OP_NONE;
    endfunction

    // Each operation on an empty set, at both ends of the key range and around zero.
    task automatic test_basic_ops();
        send_req(OP_SEARCH, 32'sd0);
        send_req(OP_REMOVE, 32'sd5);
        send_req(OP_INSERT, 32'sh7fffffff);
        send_req(OP_INSERT, 32'sh80000000);
        send_req(OP_INSERT, -32'sd1);
        send_req(OP_INSERT, 32'sd0);
        send_req(OP_INSERT, 32'sh7fffffff);      // duplicate
        send_req(OP_SEARCH, 32'sh80000000);
        send_req(OP_SEARCH, 32'sd1);             // absent
        send_req(OP_NONE,   -32'sd1);            // unused code: count only
        send_req(OP_REMOVE, 32'sh7fffffff);      // last slot
        send_req(OP_REMOVE, 32'sh80000000);      // first slot
        send_req(OP_REMOVE, 32'sd7);             // absent
        send_req(OP_SEARCH, -32'sd1);
        drain();
    endtask

    // Fill the store, then hit it with new keys, duplicates and the other operations.
    task automatic test_full_store();
        int n;
        n = 0;
        while (set_size < CAPACITY)
        begin
            send_req(OP_INSERT, 32'sh100 + n);
            n++;
        end
        send_req(OP_INSERT, 32'sh7000);          // new key into a full store
        send_req(OP_INSERT, set_keys[0]);        // duplicate while full
        send_req(OP_NONE,   32'sh7000);
        send_req(OP_SEARCH, 32'sh7fffffff);
        send_req(OP_REMOVE, set_keys[CAPACITY/2]);
        send_req(OP_INSERT, 32'sh80000000);      // back to full
        send_req(OP_INSERT, 32'sh7fffffff);
        drain();
    endtask

    // Blocks with shifting insert bias and key spread, so the set swings between empty and full.
    task automatic test_random_churn(input int blocks);
        int b;
        int i;
        int mode;
        int ins_pct;
        for (b = 0; b < blocks; b++)
        begin
            for (i = 0; i < 20; i++)
                key_pool[i] = $urandom;
            key_pool[0] = 32'sh80000000;
            key_pool[1] = 32'sh7fffffff;
            mode    = $urandom_range(0, 2);
            ins_pct = (b % 3 == 0) ? 70 : (b % 3 == 1) ? 50 : 30;
            for (i = 0; i < 100; i++)
                send_req(pick_op(ins_pct),
                         ($urandom_range(0, 9) == 0) ? pick_key(2) : pick_key(mode));
        end
        drain();
    endtask

    // Back-to-back beats with the result side never stalled.
    task automatic test_back_to_back(input int items);
        int i;
        steady = 1'b1;
        for (i = 0; i < 20; i++)
            key_pool[i] = $urandom;
        for (i = 0; i < items; i++)
            send_req(pick_op(45 + 20 * ((i / 50) % 2)), pick_key(i % 3));
        drain();
        steady = 1'b0;
    endtask

    // Result side: stall at random except during the steady stretch.
    always @(posedge clk)
        out_stall <= !steady && ($urandom_range(0, 99) < IDLE_PCT);

    // Check each result beat at mid-cycle; it is taken at the next rising edge.
    always @(negedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                log_mismatch("result beat with nothing expected");
            end
            else
            begin
                want = pending_results.pop_front();
                if (success !== want.success)
                    log_mismatch($sformatf("success expected %0b got %0b",
                                           want.success, success));
                if (full_refused !== want.full_refused)
                    log_mismatch($sformatf("full_refused expected %0b got %0b",
                                           want.full_refused, full_refused));
                if (element_count !== want.element_count)
                    log_mismatch($sformatf("element_count expected %0d got %0d",
                                           want.element_count, element_count));
            end
        end
    end

    // Watchdog: count cycles in which neither side moves a beat.
    initial
    begin
        quiet_cycles = 0;
        @(posedge rst_n);
        while (quiet_cycles < QUIET_LIMIT)
        begin
            @(negedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles = 0;
            else if (pending_results.size() != 0 || in_valid)
                quiet_cycles++;
            else
                quiet_cycles = 0;
        end
        $display("tb: watchdog expired with %0d results outstanding", pending_results.size());
        $display("tb: done, errors");
        $finish;
    end

    initial
    begin
        mismatches = 0;
        set_size   = 0;
        steady     = 1'b0;
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        func      <= OP_INSERT;
        key       <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_basic_ops();
        test_full_store();
        test_random_churn(8);
        test_back_to_back(300);

        if (pending_results.size() != 0)
            log_mismatch($sformatf("%0d expected results never arrived",
                                   pending_results.size()));
        if (mismatches == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule
